// ===== src/tsl_pkg.sv =====
// ----------------------------------------------------------------------------
// tsl_pkg: shared types and constants of the tagged sequential list
// capacity, field widths, operation codes, payload and cell link structs
// ----------------------------------------------------------------------------
package tsl_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 6;
	localparam int VAL_W    = 32;
	localparam int CHAR_W   = 8;

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic TAG_CHAR = 1'b1;

	typedef struct packed {
		logic [1:0]       kind;
		logic             tag;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] position;
	} tsl_in_t;

	typedef struct packed {
		logic             ok;
		logic             out_tag;
		logic [VAL_W-1:0] out_value;
		logic [CNT_W-1:0] count;
	} tsl_out_t;

	typedef struct packed {
		logic             tag;
		logic [VAL_W-1:0] word;
	} tsl_entry_t;

	// request as seen by every cell in the execute cycle
	typedef struct packed {
		logic             go;
		logic [1:0]       kind;
		logic             tag;
		logic [VAL_W-1:0] word;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] position;
	} tsl_bcast_t;

	// travels from cell 0 upward
	typedef struct packed {
		logic             found;
		logic             rd_hit;
		logic             rd_tag;
		logic [VAL_W-1:0] rd_word;
	} tsl_link_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} tsl_state_t;

endpackage

// ===== src/tagged_sequential_list.sv =====
// ----------------------------------------------------------------------------
// tagged_sequential_list: bounded ordered list of tagged entries
// append, remove first match with compaction, read by one-based position
// ----------------------------------------------------------------------------
// Each request is captured in the cycle it is accepted and then executed in
// the execute state, in which all 32 slot cells compare against it at once,
// shift down by one place on a removal and register the result. The input
// side is ready again in the cycle after execution; no request is taken
// while one executes. A result waiting at the output does not block
// accepting the next request, whose execute cycle waits until the output
// register is free. A character entry keeps only the low byte of its value.
// ----------------------------------------------------------------------------
module tagged_sequential_list (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tsl_pkg::tsl_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output tsl_pkg::tsl_out_t out_data
);

	tsl_pkg::tsl_state_t state_q, state_d;
	tsl_pkg::tsl_in_t    req_q;
	tsl_pkg::tsl_out_t   out_q;
	tsl_pkg::tsl_out_t   res;
	logic                out_valid_q;
	logic [tsl_pkg::CNT_W-1:0] count_q, count_d;
	logic                fire;
	tsl_pkg::tsl_bcast_t bcast;
	tsl_pkg::tsl_entry_t ent [tsl_pkg::CAPACITY];
	tsl_pkg::tsl_link_t  link [tsl_pkg::CAPACITY+1];
	tsl_pkg::tsl_link_t  tail;

	always_comb begin
		bcast.go       = fire;
		bcast.kind     = req_q.kind;
		bcast.tag      = req_q.tag;
		bcast.word     = (req_q.tag == tsl_pkg::TAG_CHAR) ?
			{{(tsl_pkg::VAL_W-tsl_pkg::CHAR_W){1'b0}}, req_q.value[tsl_pkg::CHAR_W-1:0]} :
			req_q.value;
		bcast.count    = count_q;
		bcast.position = req_q.position;
	end

	assign link[0] = '0;

	for (genvar i = 0; i < tsl_pkg::CAPACITY; i++) begin : g_cell
		tsl_pkg::tsl_entry_t upper;
		if (i == tsl_pkg::CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid
			assign upper = ent[i+1];
		end
		tsl_cell u_cell (
			.clk      (clk),
			.bcast    (bcast),
			.idx      (tsl_pkg::IDX_W'(i)),
			.upper    (upper),
			.entry    (ent[i]),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	assign tail = link[tsl_pkg::CAPACITY];

	// result and new fill
	always_comb begin
		res       = '0;
		count_d   = count_q;
		case (req_q.kind)
			tsl_pkg::KIND_APPEND: begin
				if (count_q < tsl_pkg::CNT_W'(tsl_pkg::CAPACITY)) begin
					res.ok  = 1'b1;
					count_d = count_q + tsl_pkg::CNT_W'(1);
				end
			end
			tsl_pkg::KIND_REMOVE: begin
				if (tail.found) begin
					res.ok  = 1'b1;
					count_d = count_q - tsl_pkg::CNT_W'(1);
				end
			end
			tsl_pkg::KIND_READ: begin
				res.ok        = tail.rd_hit;
				res.out_tag   = tail.rd_tag;
				res.out_value = tail.rd_word;
			end
			default: begin
				res = '0;
			end
		endcase
		res.count = count_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tsl_pkg::ST_IDLE: begin
				if (in_valid) state_d = tsl_pkg::ST_EXEC;
			end
			tsl_pkg::ST_EXEC: begin
				if (fire) state_d = tsl_pkg::ST_IDLE;
			end
			default: state_d = tsl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		fire     = 1'b0;
		case (state_q)
			tsl_pkg::ST_IDLE: in_ready = 1'b1;
			tsl_pkg::ST_EXEC: fire = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
				fire     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsl_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) req_q <= in_data;
		if (fire) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_fire_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("executed request did not show a result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tsl_pkg::CNT_W'(tsl_pkg::CAPACITY))
		else $error("fill count beyond capacity");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !res.ok) |=> (count_q == $past(count_q)))
		else $error("failed request changed the fill count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.ok) |-> (out_q.out_value == '0 && !out_q.out_tag))
		else $error("failed request returned entry data");

	a_count_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (out_q.count == count_q))
		else $error("reported count differs from fill count");

endmodule

// ===== src/tsl_cell.sv =====
// ----------------------------------------------------------------------------
// tsl_cell: one list slot
// holds one entry, compares it against a remove request, takes the entry of
// its upper neighbor when the list closes a gap, and joins the read chain
// ----------------------------------------------------------------------------
module tsl_cell (
	input  logic                       clk,
	input  tsl_pkg::tsl_bcast_t        bcast,
	input  logic [tsl_pkg::IDX_W-1:0]  idx,
	input  tsl_pkg::tsl_entry_t        upper,
	output tsl_pkg::tsl_entry_t        entry,
	input  tsl_pkg::tsl_link_t         link_in,
	output tsl_pkg::tsl_link_t         link_out
);

	tsl_pkg::tsl_entry_t entry_q;
	logic [tsl_pkg::CNT_W-1:0] pos_here;
	logic occupied;
	logic match;
	logic rd_hit;
	logic wr_append;
	logic wr_shift;

	assign pos_here  = tsl_pkg::CNT_W'(idx);
	assign occupied  = pos_here < bcast.count;
	assign match     = occupied && (bcast.kind == tsl_pkg::KIND_REMOVE) &&
		(entry_q.tag == bcast.tag) && (entry_q.word == bcast.word);
	assign rd_hit    = occupied && (bcast.kind == tsl_pkg::KIND_READ) &&
		((pos_here + tsl_pkg::CNT_W'(1)) == bcast.position);
	// a full list never has a slot index equal to the count
	assign wr_append = (bcast.kind == tsl_pkg::KIND_APPEND) && (pos_here == bcast.count);
	// at or above the first match, take the upper neighbor
	assign wr_shift  = link_out.found;

	always_comb begin
		link_out.found   = link_in.found | match;
		link_out.rd_hit  = link_in.rd_hit | rd_hit;
		link_out.rd_tag  = link_in.rd_tag | (rd_hit & entry_q.tag);
		link_out.rd_word = link_in.rd_word | ({tsl_pkg::VAL_W{rd_hit}} & entry_q.word);
	end

	always_ff @(posedge clk) begin
		if (bcast.go) begin
			if (wr_append) begin
				entry_q <= '{tag: bcast.tag, word: bcast.word};
			end else if (wr_shift) begin
				entry_q <= upper;
			end
		end
	end

	assign entry = entry_q;

endmodule
